// ===== sv/seven_segment_frame_serializer_defines.svh =====
// Assertion macros used by the checker file of the seven-segment frame serializer.
`ifndef SEVEN_SEGMENT_FRAME_SERIALIZER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_SERIALIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ssfs_pkg.sv =====
// Types, constants and segment tables of the seven-segment frame serializer.
`default_nettype none

package ssfs_pkg;

    typedef struct packed {
        logic [7:0]  led_pattern;
        logic [15:0] display_value;
        logic [2:0]  point_enables;
    } in_item_t;

    typedef struct packed {
        logic       serial_bit;
        logic [4:0] bit_position;
        logic       latch_after;
    } out_item_t;

    localparam int FRAME_BITS = 32;

    typedef logic [FRAME_BITS-1:0] frame_t;

    localparam logic [4:0] LAST_POS = 5'd31;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x.
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Point segment positions in the frame.
    localparam int ONES_POINT_BIT     = 15;
    localparam int TENS_POINT_BIT     = 11;
    localparam int HUNDREDS_POINT_BIT = 31;

    // Segment pattern of a digit at the outer positions (hundreds and ones).
    function automatic logic [15:0] outer_seg(input logic [3:0] digit);
        logic [15:0] seg;
        case (digit)
            4'd0:    seg = 16'h7007;
            4'd1:    seg = 16'h4001;
            4'd2:    seg = 16'h300B;
            4'd3:    seg = 16'h600B;
            4'd4:    seg = 16'h400D;
            4'd5:    seg = 16'h600E;
            4'd6:    seg = 16'h700E;
            4'd7:    seg = 16'h4003;
            4'd8:    seg = 16'h700F;
            4'd9:    seg = 16'h600F;
            default: seg = 16'h0000;
        endcase
        return seg;
    endfunction

    // Segment pattern of a digit at the middle (tens) position.
    function automatic logic [15:0] middle_seg(input logic [3:0] digit);
        logic [15:0] seg;
        case (digit)
            4'd0:    seg = 16'h0770;
            4'd1:    seg = 16'h0410;
            4'd2:    seg = 16'h03B0;
            4'd3:    seg = 16'h06B0;
            4'd4:    seg = 16'h04D0;
            4'd5:    seg = 16'h06E0;
            4'd6:    seg = 16'h07E0;
            4'd7:    seg = 16'h0430;
            4'd8:    seg = 16'h07F0;
            4'd9:    seg = 16'h06F0;
            default: seg = 16'h0000;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssfs_front.sv =====
// Front end: accepts an item, extracts three decimal digits and assembles the frame.
`default_nettype none

module ssfs_front
    import ssfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          frame_push,
    input  wire logic     frame_full,
    output frame_t        frame
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_REM, S_SEND} state_t;

    state_t      state_reg;
    logic [15:0] val_reg;
    logic [15:0] quot_reg;
    logic [1:0]  digit_idx_reg;
    logic [3:0]  digit_reg [3];
    logic [7:0]  led_reg;
    logic [2:0]  points_reg;

    logic [32:0] product;
    logic [15:0] quot_next;
    logic [15:0] times_ten;
    logic [15:0] remainder;
    logic [7:0]  led_order;

    assign full = (state_reg != S_IDLE);

    assign product   = 33'(val_reg) * 33'(DIV10_MUL);
    assign quot_next = 16'(product >> DIV10_SHIFT);
    assign times_ten = {quot_reg[12:0], 3'b000} + {quot_reg[14:0], 1'b0};
    assign remainder = val_reg - times_ten;

    // The upper nibble of the LED pattern is wired in reverse order.
    assign led_order = {led_reg[4], led_reg[5], led_reg[6], led_reg[7], led_reg[3:0]};

    always_comb
    begin
        frame = {outer_seg(digit_reg[2]), 16'h0000}
              | {16'h0000, middle_seg(digit_reg[1])}
              | {16'h0000, outer_seg(digit_reg[0])}
              | {4'h0, led_order, 20'h00000};
        frame[ONES_POINT_BIT]     = frame[ONES_POINT_BIT] | points_reg[0];
        frame[TENS_POINT_BIT]     = frame[TENS_POINT_BIT] | points_reg[1];
        frame[HUNDREDS_POINT_BIT] = frame[HUNDREDS_POINT_BIT] | points_reg[2];
    end

    assign frame_push = (state_reg == S_SEND) && !frame_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            digit_idx_reg <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (push)
                    begin
                        val_reg       <= item.display_value;
                        led_reg       <= item.led_pattern;
                        points_reg    <= item.point_enables;
                        digit_idx_reg <= 2'd0;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    quot_reg  <= quot_next;
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    // Digits come out ones first, then tens, then hundreds.
                    digit_reg[digit_idx_reg] <= remainder[3:0];
                    val_reg                  <= quot_reg;
                    digit_idx_reg            <= digit_idx_reg + 2'd1;
                    state_reg                <= (digit_idx_reg == 2'd2) ? S_SEND : S_DIV;
                end
                S_SEND:
                begin
                    if (!frame_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssfs_queue.sv =====
// Short frame queue that decouples the front end from the serial back end.
`default_nettype none

module ssfs_queue
    import ssfs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire frame_t wdata,
    output logic        full,
    input  wire logic   rd,
    output frame_t      rdata,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_wr;
    logic do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssfs_back.sv =====
// Back end: shifts each frame out one bit per result item, least significant bit first.
`default_nettype none

module ssfs_back
    import ssfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   frame_empty,
    input  wire frame_t frame,
    output logic        frame_pop,
    output logic        empty,
    input  wire logic   pop,
    output out_item_t   result
);

    frame_t     shift_reg;
    logic [4:0] pos_reg;
    logic       valid_reg;

    logic take;
    logic last;
    logic load;

    assign take = valid_reg && pop;
    assign last = (pos_reg == LAST_POS);

    // A queued frame loads as the last bit of the previous one leaves, so frames run gapless.
    assign load      = !frame_empty && (!valid_reg || (take && last));
    assign frame_pop = load;

    assign empty               = !valid_reg;
    assign result.serial_bit   = shift_reg[0];
    assign result.bit_position = pos_reg;
    assign result.latch_after  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 5'd0;
        end
        else if (load)
        begin
            shift_reg <= frame;
            pos_reg   <= 5'd0;
            valid_reg <= 1'b1;
        end
        else if (take && last)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            shift_reg <= {1'b0, shift_reg[FRAME_BITS-1:1]};
            pos_reg   <= pos_reg + 5'd1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/seven_segment_frame_serializer.sv =====
// An item's frame passes the front end's divide steps, the frame queue and the back-end shift
// register before its first bit is on the result ports. Each item gives 32 result items, one per
// cycle while pop is held; the item rate is set by the single serial shift register in the back
// end. The front end takes one item at a time (accept, three divide-by-ten steps, hand-off) and
// runs ahead through the frame queue. Reset clears all control state; no clearing pass.
`default_nettype none

module seven_segment_frame_serializer
    import ssfs_pkg::*;
#(
    parameter int FRAME_QUEUE_DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    logic   q_wr;
    logic   q_full;
    frame_t q_wdata;
    logic   q_rd;
    logic   q_empty;
    frame_t q_rdata;

    ssfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .frame_push (q_wr),
        .frame_full (q_full),
        .frame      (q_wdata)
    );

    ssfs_queue #(
        .DEPTH (FRAME_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ssfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_empty (q_empty),
        .frame       (q_rdata),
        .frame_pop   (q_rd),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== sv/ssfs_checker.sv =====
// Port-level checker for the seven-segment frame serializer and its bind statement.
`default_nettype none

`include "seven_segment_frame_serializer_defines.svh"

module ssfs_checker
    import ssfs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire out_item_t result
);

    `SSFS_ASSERT_NOW(a_latch_on_last, !empty, result.latch_after == (result.bit_position == LAST_POS), "latch_after must mark exactly bit 31")

    `SSFS_ASSERT_NEXT(a_bit_advance, pop && !empty && !result.latch_after, !empty && (result.bit_position == $past(result.bit_position) + 5'd1), "frame bits must follow in order without a gap")

    `SSFS_ASSERT_NEXT(a_frame_restart, pop && !empty && result.latch_after, empty || (result.bit_position == 5'd0), "a new frame must start at bit 0")

    `SSFS_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(result), "a waiting item must hold")

endmodule

bind seven_segment_frame_serializer ssfs_checker u_ssfs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
